### sv/arp_pkg.sv
// Package for the address-resolution cache: table size, field widths,
// entry layout and scan state encoding. No dependencies.
`default_nettype none

package arp_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Field widths
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int SLOT_W  = 4;
    localparam int ENTRY_W = IP_W + MAC_W;

    // Broadcast MAC returned on a lookup miss
    localparam logic [MAC_W-1:0] BROADCAST_MAC = {MAC_W{1'b1}};

    // Item kinds
    typedef enum logic {
        KIND_LEARN  = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    // Scan sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

endpackage

`default_nettype wire

### sv/arp_cache_table.sv
// Address-resolution cache top level: IPv4-to-MAC table with a scanned
// entry memory and flip-flop valid bits. Depends on arp_pkg.
`default_nettype none

// Usage
//   Input: drive i_kind, i_ip_address, i_mac_in and raise start; the item is
//   taken at the clock edge where start is high and busy is low. busy stays
//   high until the result has been issued.
//   Output: o_done pulses for one cycle with o_found, o_mac_out, o_slot.
//   The receiver cannot stall; every result must be taken in that cycle.
//   Kind learn stores the mapping in the first free or matching slot (slot 0
//   when the table is full with no match); kind lookup returns the MAC of the
//   first valid matching slot, or all-ones on a miss.
// Timing
//   The entry memory is read one slot per cycle through a registered read port.
//   Each slot is checked when its data comes back, and the outcome is registered
//   onto the outputs; a miss scans every slot up to the last one.
//   The next item may be accepted in the cycle o_done is high.
// Reset
//   i_rst_n is synchronous and active low; it clears all valid bits at once,
//   so no clearing pass is needed. Entry contents are left as they are.
module arp_cache_table
    import arp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_kind,
    input  wire logic [IP_W-1:0]    i_ip_address,
    input  wire logic [MAC_W-1:0]   i_mac_in,
    output logic                    o_done,
    output logic                    o_found,
    output logic [MAC_W-1:0]        o_mac_out,
    output logic [SLOT_W-1:0]       o_slot
);

    // Entry memory {ip, mac} and valid bits
    logic [ENTRY_W-1:0]       r_mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0]       r_rd_data;
    logic [TABLE_ENTRIES-1:0] r_entry_valid;

    // Sequencer and captured item
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_issued_all, n_issued_all;
    logic [IDX_W-1:0]  r_chk_idx;
    logic              r_chk_vld, n_chk_vld;
    logic              r_kind;
    logic [IP_W-1:0]   r_ip;
    logic [MAC_W-1:0]  r_mac_in;

    // Result registers
    logic              r_done, n_done;
    logic              r_found, n_found;
    logic [MAC_W-1:0]  r_mac_out, n_mac_out;
    logic [SLOT_W-1:0] r_slot, n_slot;

    // Write-back control
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;

    logic              accept;
    logic              ip_match;
    logic              slot_valid;
    logic              last_chk;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    assign accept     = start && (r_state == ST_IDLE);
    assign ip_match   = (r_rd_data[ENTRY_W-1 -: IP_W] == r_ip);
    assign slot_valid = r_entry_valid[r_chk_idx];
    assign last_chk   = (r_chk_idx == LAST_IDX);

    // Scan decision: evaluate the slot whose data just came back
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_issued_all = r_issued_all;
        n_chk_vld    = 1'b0;
        n_done       = 1'b0;
        n_found      = r_found;
        n_mac_out    = r_mac_out;
        n_slot       = r_slot;
        wr_en        = 1'b0;
        wr_idx       = r_chk_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state      = ST_SCAN;
                    n_idx        = '0;
                    n_issued_all = 1'b0;
                end
            end
            ST_SCAN: begin
                // Advance the read pointer
                if (!r_issued_all) begin
                    n_chk_vld = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_issued_all = 1'b1;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                if (r_chk_vld) begin
                    if (r_kind == KIND_LEARN) begin
                        if (!slot_valid || ip_match || last_chk) begin
                            wr_en     = 1'b1;
                            wr_idx    = (!slot_valid || ip_match) ? r_chk_idx : '0;
                            n_found   = slot_valid && ip_match;
                            n_mac_out = r_mac_in;
                            n_slot    = SLOT_W'(wr_idx);
                            n_done    = 1'b1;
                            n_state   = ST_IDLE;
                            n_chk_vld = 1'b0;
                        end
                    end else begin
                        if (slot_valid && ip_match) begin
                            n_found   = 1'b1;
                            n_mac_out = r_rd_data[MAC_W-1:0];
                            n_slot    = SLOT_W'(r_chk_idx);
                            n_done    = 1'b1;
                            n_state   = ST_IDLE;
                            n_chk_vld = 1'b0;
                        end else if (last_chk) begin
                            n_found   = 1'b0;
                            n_mac_out = BROADCAST_MAC;
                            n_slot    = '0;
                            n_done    = 1'b1;
                            n_state   = ST_IDLE;
                            n_chk_vld = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= {r_ip, r_mac_in};
        end
        r_rd_data <= r_mem[r_idx];
    end

    // Control state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_idx         <= '0;
            r_issued_all  <= 1'b0;
            r_chk_vld     <= 1'b0;
            r_done        <= 1'b0;
            r_entry_valid <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_issued_all <= n_issued_all;
            r_chk_vld    <= n_chk_vld;
            r_done       <= n_done;
            if (wr_en) begin
                r_entry_valid[wr_idx] <= 1'b1;
            end
        end
    end

    // Payload: captured item, pipeline index, result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_ip     <= i_ip_address;
            r_mac_in <= i_mac_in;
        end
        r_chk_idx <= r_idx;
        r_found   <= n_found;
        r_mac_out <= n_mac_out;
        r_slot    <= n_slot;
    end

    assign busy      = (r_state != ST_IDLE);
    assign o_done    = r_done;
    assign o_found   = r_found;
    assign o_mac_out = r_mac_out;
    assign o_slot    = r_slot;

endmodule

`default_nettype wire

### tb/sv/tb_arp_cache_table.sv
// Testbench for arp_cache_table: drives learn and lookup items, predicts each
// reply from a local copy of the table and checks it. Depends on arp_pkg.
`default_nettype none

module tb_arp_cache_table;
    import arp_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int END_CYCLES = TABLE_ENTRIES + 4;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_kind             kind;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        int                gap;
        bit                wait_drain;
    } t_arp_item;

    typedef struct packed {
        logic              found;
        logic [MAC_W-1:0]  mac;
        logic [SLOT_W-1:0] slot;
    } t_arp_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_kind = 1'b0;
    logic [IP_W-1:0]   i_ip_address = '0;
    logic [MAC_W-1:0]  i_mac_in = '0;
    logic              o_done;
    logic              o_found;
    logic [MAC_W-1:0]  o_mac_out;
    logic [SLOT_W-1:0] o_slot;

    // Local copy of the cache
    bit                tbl_valid [TABLE_ENTRIES];
    logic [IP_W-1:0]   tbl_ip    [TABLE_ENTRIES];
    logic [MAC_W-1:0]  tbl_mac   [TABLE_ENTRIES];

    t_arp_item  request_queue[$];
    t_arp_reply reply_queue[$];

    int unsigned accept_count = 0;
    int unsigned issue_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;

    t_arp_item staged;
    bit        have_staged = 1'b0;
    int        gap_left = 0;

    arp_cache_table dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_ip_address (i_ip_address),
        .i_mac_in     (i_mac_in),
        .o_done       (o_done),
        .o_found      (o_found),
        .o_mac_out    (o_mac_out),
        .o_slot       (o_slot)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Resolve one item against the local table and update it on a learn
    function automatic t_arp_reply resolve_item(t_kind kind, logic [IP_W-1:0] ip,
                                                logic [MAC_W-1:0] mac);
        t_arp_reply r;
        int         target;
        bit         hit;
        bit         scanned;
        target  = 0;
        hit     = 1'b0;
        scanned = 1'b0;
        if (kind == KIND_LEARN) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!scanned) begin
                    if (!tbl_valid[i]) begin
                        target  = i;
                        scanned = 1'b1;
                    end else if (tbl_ip[i] == ip) begin
                        target  = i;
                        hit     = 1'b1;
                        scanned = 1'b1;
                    end
                end
            end
            // Full table with no match falls back to slot 0
            tbl_ip[target]    = ip;
            tbl_mac[target]   = mac;
            tbl_valid[target] = 1'b1;
            r.found = hit;
            r.mac   = mac;
            r.slot  = target[SLOT_W-1:0];
        end else begin
            r.found = 1'b0;
            r.mac   = BROADCAST_MAC;
            r.slot  = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!scanned && tbl_valid[i] && tbl_ip[i] == ip) begin
                    r.found = 1'b1;
                    r.mac   = tbl_mac[i];
                    r.slot  = i[SLOT_W-1:0];
                    scanned = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    task automatic add_item(t_kind kind, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                            int gap, bit wait_drain);
        t_arp_item it;
        it.kind       = kind;
        it.ip         = ip;
        it.mac        = mac;
        it.gap        = gap;
        it.wait_drain = wait_drain;
        request_queue.push_back(it);
    endtask

    // Driver: present items at the falling edge, hold until taken
    always @(negedge i_clk) begin
        bit next_start;
        next_start = 1'b0;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else if (start && accept_count != issue_count) begin
            next_start = 1'b1;
        end else begin
            if (!have_staged && request_queue.size() != 0) begin
                staged      = request_queue.pop_front();
                have_staged = 1'b1;
                gap_left    = staged.gap;
            end
            if (have_staged) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(staged.wait_drain &&
                               (reply_queue.size() != 0 || accept_count != issue_count))) begin
                    i_kind       <= staged.kind;
                    i_ip_address <= staged.ip;
                    i_mac_in     <= staged.mac;
                    next_start   = 1'b1;
                    issue_count++;
                    have_staged  = 1'b0;
                end
            end
        end
        start <= next_start;
    end

    // Monitor: check replies, then predict for a newly taken item
    always @(posedge i_clk) begin
        t_arp_reply got;
        t_arp_reply want;
        if (i_rst_n) begin
            if (o_done) begin
                got = '{o_found, o_mac_out, o_slot};
                if (reply_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected reply: found=%0b mac=%h slot=%0d",
                                 got.found, got.mac, got.slot);
                end else begin
                    want = reply_queue.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"reply mismatch: expected found=%0b mac=%h slot=%0d,",
                                      " got found=%0b mac=%h slot=%0d"},
                                     want.found, want.mac, want.slot,
                                     got.found, got.mac, got.slot);
                    end
                end
            end
            if (start && !busy) begin
                reply_queue.push_back(resolve_item(t_kind'(i_kind), i_ip_address, i_mac_in));
                accept_count++;
            end
        end
    end

    // Watchdog: end the run when no item is taken for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        logic [IP_W-1:0] ip_pool [24];
        logic [IP_W-1:0] ip;
        bit              burst;
        int              gap;
        t_kind           kind;

        // Misses on an empty table at both address extremes
        add_item(KIND_LOOKUP, '0, random_mac(), $urandom_range(0, 10), 1'b0);
        add_item(KIND_LOOKUP, '1, random_mac(), $urandom_range(0, 10), 1'b0);
        // Learn both extremes of address and MAC, then hit them
        add_item(KIND_LEARN, '0, '0, $urandom_range(0, 10), 1'b0);
        add_item(KIND_LEARN, '1, '1, $urandom_range(0, 10), 1'b0);
        add_item(KIND_LOOKUP, '0, random_mac(), $urandom_range(0, 10), 1'b0);
        add_item(KIND_LOOKUP, '1, random_mac(), $urandom_range(0, 10), 1'b0);
        // Relearn an address already present: update in place
        add_item(KIND_LEARN, '0, random_mac(), $urandom_range(0, 10), 1'b0);
        add_item(KIND_LOOKUP, '0, random_mac(), $urandom_range(0, 10), 1'b0);
        // Fill the remaining slots
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 1; i <= TABLE_ENTRIES - 2; i++) begin
            ip_pool[i + 1] = i * 32'h1111_1111;
            add_item(KIND_LEARN, ip_pool[i + 1], random_mac(), $urandom_range(0, 10), 1'b0);
        end
        // Full table without a match evicts slot 0
        ip_pool[16] = 32'h0F0F_F0F0;
        add_item(KIND_LEARN, ip_pool[16], random_mac(), $urandom_range(0, 10), 1'b0);
        add_item(KIND_LOOKUP, '0, random_mac(), $urandom_range(0, 10), 1'b0);
        add_item(KIND_LOOKUP, ip_pool[16], random_mac(), $urandom_range(0, 10), 1'b0);

        for (int i = 17; i < 24; i++)
            ip_pool[i] = $urandom;

        // Random traffic, mostly on a small address pool so hits and updates occur
        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap  = burst ? 0 : $urandom_range(0, 10);
            kind = ($urandom_range(0, 1) == 0) ? KIND_LEARN : KIND_LOOKUP;
            if ($urandom_range(0, 9) < 7)
                ip = ip_pool[$urandom_range(0, 23)];
            else
                ip = $urandom;
            add_item(kind, ip, random_mac(), gap, (n == 0) || ($urandom_range(0, 49) == 0));
        end

        // Drain, then keep clocking to catch stray replies before the verdict
        while (request_queue.size() != 0 || have_staged || accept_count != issue_count ||
               reply_queue.size() != 0)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && reply_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
sv/arp_pkg.sv
sv/arp_cache_table.sv
tb/sv/tb_arp_cache_table.sv
